// ===== rtl/octave_band_preset_classifier_core_assert.svh =====
// assertion macros for the octave band preset classifier
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef OCTAVE_BAND_PRESET_CLASSIFIER_CORE_ASSERT_SVH
`define OCTAVE_BAND_PRESET_CLASSIFIER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OBPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("obpc assertion failed");
`define OBPC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("obpc forbidden condition");
`else
`define OBPC_ASSERT(lbl, prop)
`define OBPC_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/obpc_pkg.sv =====
// package for the octave band preset classifier: payload types, sizes,
// band edges, preset targets and the twiddle tables built at elaboration
// no dependencies
package obpc_pkg;

  localparam int unsigned N_SAMPLES = 1024;
  localparam int unsigned ADDR_W    = $clog2(N_SAMPLES);
  localparam int unsigned CNT_W     = ADDR_W + 1;
  localparam int unsigned BIN_W     = ADDR_W - 1;
  localparam int unsigned NBANDS    = 10;
  localparam int unsigned BAND_W    = 4;
  localparam int unsigned SR_W      = 18;
  localparam int unsigned F_W       = BIN_W + SR_W;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned TW_W      = 32;
  localparam int unsigned PROD_W    = SMP_W + TW_W;
  localparam int unsigned ACC_W     = PROD_W + ADDR_W;
  localparam int unsigned RND_W     = ACC_W - 32;
  localparam int unsigned SQ_W      = 2 * RND_W + 2;
  localparam int unsigned ROOT_W    = SQ_W / 2;
  localparam int unsigned BAND_E_W  = 48;
  localparam int unsigned TOT_W     = BAND_E_W + 4;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned SHARE_W   = 17;
  localparam int unsigned SCORE_W   = 2 * SHARE_W + 4;
  localparam int unsigned TGT_IDX_W = $clog2(NBANDS * NBANDS);

  localparam logic [SR_W-1:0] SR_RESET = SR_W'(44100);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_LEN = 1'b1;

  localparam longint unsigned QONE        = 64'd1073741824;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned BAND_EDGE [NBANDS+1] = '{
    22, 44, 88, 177, 354, 707, 1414, 2828, 5657, 11314, 22627
  };

  localparam int unsigned SHAPE [NBANDS][NBANDS] = '{
    '{2,5,6,4,1,1,1,2,6,7},
    '{2,3,4,2,2,2,2,3,4,5},
    '{6,6,5,2,1,1,1,2,5,6},
    '{2,3,4,5,2,2,5,5,3,5},
    '{6,6,6,4,2,2,1,1,1,1},
    '{1,1,1,1,1,2,4,6,6,6},
    '{2,2,2,5,7,7,7,5,4,4},
    '{2,6,6,4,2,2,2,2,3,4},
    '{0,2,2,4,4,2,2,2,4,5},
    '{2,2,2,5,5,5,2,5,5,7}
  };

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } obpc_in_t;

  typedef struct packed {
    logic [BAND_W-1:0] preset_index;
    logic              status;
  } obpc_out_t;

  typedef logic signed [TW_W-1:0] tw_rom_t [N_SAMPLES];
  typedef logic [SHARE_W-1:0] tgt_rom_t [NBANDS*NBANDS];

  // shift-subtract quotient, used only while elaborating the tables
  function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor series of cos and sin on a q30 angle in [0, pi/2], {cos, sin}
  function automatic logic [127:0] tw_series(longint unsigned x);
    longint unsigned term;
    longint          ac;
    longint          as;
    term = QONE;
    ac   = longint'(QONE);
    as   = 0;
    for (int n = 1; n <= 20; n++) begin
      term = udiv((term * x) >> 30, longint'(n));
      case (n & 3)
        0:       ac = ac + longint'(term);
        1:       as = as + longint'(term);
        2:       ac = ac - longint'(term);
        default: as = as - longint'(term);
      endcase
    end
    return {ac, as};
  endfunction

  function automatic tw_rom_t build_tw(bit want_sin);
    tw_rom_t         rom;
    longint unsigned mm;
    longint unsigned th;
    bit              neg_s;
    bit              neg_c;
    logic [127:0]    cs;
    longint          c;
    longint          s;
    for (int m = 0; m < N_SAMPLES; m++) begin
      mm    = longint'(m);
      neg_s = 1'b0;
      neg_c = 1'b0;
      if (2 * mm > N_SAMPLES) begin
        mm    = N_SAMPLES - mm;
        neg_s = 1'b1;
      end
      th = udiv(TWO_PI_Q30 * mm, N_SAMPLES);
      if (th > HALF_PI_Q30) begin
        th    = (th >= PI_Q30) ? 0 : PI_Q30 - th;
        neg_c = 1'b1;
      end
      cs = tw_series(th);
      c  = cs[127:64];
      s  = cs[63:0];
      if (want_sin) rom[m] = TW_W'(neg_s ? -s : s);
      else          rom[m] = TW_W'(neg_c ? -c : c);
    end
    return rom;
  endfunction

  // preset targets in q0.16, rounded half up against the row sum
  function automatic tgt_rom_t build_tgt();
    tgt_rom_t        t;
    longint unsigned rs;
    for (int p = 0; p < NBANDS; p++) begin
      rs = 0;
      for (int j = 0; j < NBANDS; j++) rs = rs + SHAPE[p][j];
      for (int j = 0; j < NBANDS; j++) begin
        t[p*NBANDS+j] = SHARE_W'(udiv((longint'(SHAPE[p][j]) << 16) + (rs >> 1), rs));
      end
    end
    return t;
  endfunction

  localparam tw_rom_t  COS_ROM = build_tw(1'b0);
  localparam tw_rom_t  SIN_ROM = build_tw(1'b1);
  localparam tgt_rom_t TGT_ROM = build_tgt();

endpackage

// ===== rtl/octave_band_preset_classifier_core.sv =====
// octave band preset classifier, top level
// depends on obpc_pkg and octave_band_preset_classifier_core_assert.svh
//
// usage:
//   samples come in on sample_i with start; a transfer happens at a clock
//   edge with start high and busy low. the sample that carries last closes
//   the frame. each frame gives one result on result_o, marked by done_o for
//   one cycle; the receiver cannot stall it.
//   a frame of the wrong length gives status 1 and preset 0 in the cycle
//   after its last sample, and busy stays low.
//   a frame of 1024 samples starts the evaluation: busy goes high over
//   all 512 bins, then done_o pulses as busy drops. the time is set by
//   the direct transform: one multiply-accumulate per cycle over the
//   sample memory and twiddle rom, then per bin a 27 step square root and
//   a 64 step shared divider. sample_rate is written through cfg_we_i /
//   cfg_wdata_i; the user must write it only while idle, the block itself
//   does not enforce this. reset returns the sample count to zero and the
//   rate to 44100; the sample memory is not cleared, a full frame always
//   rewrites it.
`include "octave_band_preset_classifier_core_assert.svh"

module octave_band_preset_classifier_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  obpc_pkg::obpc_in_t      sample_i,
  input  logic                    cfg_we_i,
  input  logic [obpc_pkg::SR_W-1:0] cfg_wdata_i,
  output logic                    done_o,
  output obpc_pkg::obpc_out_t     result_o
);
  import obpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BIN, S_MAC, S_RND, S_SQ, S_SUM, S_SQRT, S_DIV,
    S_BAND, S_TOT, S_SHR, S_DIF, S_MUL, S_ACC
  } state_e;

  localparam logic [CNT_W-1:0] CNT_N   = CNT_W'(N_SAMPLES);
  localparam logic [BIN_W-1:0] K_LAST  = {BIN_W{1'b1}};
  localparam logic [ADDR_W-1:0] N_LAST = {ADDR_W{1'b1}};
  localparam logic [BAND_W-1:0] J_LAST = BAND_W'(NBANDS - 1);
  localparam logic [6:0] DIV_LAST      = 7'(DIV_W - 1);
  localparam logic [6:0] SQRT_LAST     = 7'(ROOT_W - 1);

  state_e                     state_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [SR_W-1:0]            sr_q;
  logic [BIN_W-1:0]           k_q;
  logic [ADDR_W-1:0]          n_q, idx_q;
  logic                       iss_done_q, v1_q, v2_q;
  logic signed [SMP_W-1:0]    x_q;
  logic signed [TW_W-1:0]     c_q, s_q;
  logic signed [PROD_W-1:0]   pre_q, pim_q;
  logic signed [ACC_W-1:0]    re_q, im_q;
  logic [RND_W-1:0]           r_q, i_q;
  logic [2*RND_W-1:0]         rr_q, ii_q;
  logic [SQ_W-1:0]            rad_q;
  logic [ROOT_W-1:0]          root_q;
  logic [ROOT_W+1:0]          rem_q;
  logic [6:0]                 step_q;
  logic [DIV_W-1:0]           div_num_q;
  logic [TOT_W-1:0]           div_den_q;
  logic [TOT_W:0]             div_rem_q;
  logic                       div_ret_q;
  logic [ROOT_W-1:0]          mag_q;
  logic [F_W-1:0]             f_q;
  logic [BAND_E_W-1:0]        band_q [NBANDS];
  logic [TOT_W-1:0]           total_q;
  logic [SHARE_W-1:0]         share_q [NBANDS];
  logic [BAND_W-1:0]          j_q, p_q, best_q;
  logic signed [SHARE_W:0]    d_q;
  logic [2*SHARE_W-1:0]       sqd_q;
  logic [SCORE_W-1:0]         score_q, best_score_q;
  logic                       done_q;
  obpc_out_t                  res_q;

  logic signed [SMP_W-1:0]    smem [N_SAMPLES];

  logic                       accept, wr_en, rd_en;
  logic                       done_d;
  logic [CNT_W-1:0]           cnt_d;
  logic [SR_W-1:0]            sr_eff;
  logic [ACC_W-1:0]           re_abs, im_abs, re_rnd, im_rnd;
  logic [ROOT_W+1:0]          sq_rem, sq_trial;
  logic [TOT_W:0]             dv_rem;
  logic                       dv_bit;
  logic [DIV_W-1:0]           div_num_d;
  logic                       band_hit;
  logic [BAND_W-1:0]          band_idx, band_sel;
  logic [BAND_E_W-1:0]        band_rd;
  logic [TGT_IDX_W-1:0]       tgt_idx;
  logic signed [2*SHARE_W+1:0] sq_full;
  logic [SCORE_W-1:0]         score_d;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (cnt_q < CNT_N);
  assign cnt_d  = (cnt_q <= CNT_N) ? cnt_q + 1'b1 : cnt_q;
  assign rd_en  = (state_q == S_MAC) && !iss_done_q;
  assign sr_eff = (sr_q == '0) ? SR_W'(1) : sr_q;

  // result strobe: wrong length at the last transfer, or the last preset scored
  assign done_d = (accept && sample_i.last && (cnt_d != CNT_N)) ||
                  ((state_q == S_ACC) && (j_q == J_LAST) && (p_q == J_LAST));

  // round half away from zero, q30 to integer
  assign re_abs = re_q[ACC_W-1] ? ACC_W'(-re_q) : ACC_W'(re_q);
  assign im_abs = im_q[ACC_W-1] ? ACC_W'(-im_q) : ACC_W'(im_q);
  assign re_rnd = re_abs + (ACC_W'(1) << 29);
  assign im_rnd = im_abs + (ACC_W'(1) << 29);

  // one bit of the integer square root
  assign sq_rem   = {rem_q[ROOT_W-1:0], rad_q[SQ_W-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};

  // one bit of the restoring divider
  always_comb begin
    dv_rem = {div_rem_q[TOT_W-1:0], div_num_q[DIV_W-1]};
    dv_bit = (dv_rem >= {1'b0, div_den_q});
    if (dv_bit) dv_rem = dv_rem - {1'b0, div_den_q};
    div_num_d = {div_num_q[DIV_W-2:0], dv_bit};
  end

  // octave band of the current bin, lower edge inclusive
  always_comb begin
    band_hit = 1'b0;
    band_idx = '0;
    for (int j = NBANDS - 1; j >= 0; j--) begin
      if (f_q < F_W'(BAND_EDGE[j+1] * N_SAMPLES)) band_idx = BAND_W'(j);
    end
    band_hit = (f_q >= F_W'(BAND_EDGE[0] * N_SAMPLES)) &&
               (f_q < F_W'(BAND_EDGE[NBANDS] * N_SAMPLES));
  end

  assign band_sel = (state_q == S_BAND) ? band_idx : j_q;
  assign band_rd  = band_q[band_sel];
  assign tgt_idx  = TGT_IDX_W'(p_q * NBANDS) + TGT_IDX_W'(j_q);
  assign sq_full  = d_q * d_q;
  assign score_d  = score_q + SCORE_W'(sqd_q);

  // sample memory and twiddle roms, registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) smem[cnt_q[ADDR_W-1:0]] <= sample_i.sample;
    if (rd_en) begin
      x_q <= smem[n_q];
      c_q <= COS_ROM[idx_q];
      s_q <= SIN_ROM[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      sr_q         <= SR_RESET;
      k_q          <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      iss_done_q   <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      step_q       <= '0;
      div_ret_q    <= 1'b0;
      total_q      <= '0;
      j_q          <= '0;
      p_q          <= '0;
      best_q       <= '0;
      done_q       <= 1'b0;
      res_q        <= '0;
      for (int j = 0; j < NBANDS; j++) band_q[j] <= '0;
    end else begin
      done_q <= done_d;
      if (cfg_we_i) sr_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (sample_i.last) begin
              cnt_q <= '0;
              if (cnt_d == CNT_N) begin
                k_q     <= '0;
                total_q <= TOT_W'(1);
                for (int j = 0; j < NBANDS; j++) band_q[j] <= '0;
                state_q <= S_BIN;
              end else begin
                res_q.preset_index <= '0;
                res_q.status       <= STATUS_LEN;
              end
            end else begin
              cnt_q <= cnt_d;
            end
          end
        end
        S_BIN: begin
          re_q       <= '0;
          im_q       <= '0;
          n_q        <= '0;
          idx_q      <= '0;
          iss_done_q <= 1'b0;
          v1_q       <= 1'b0;
          v2_q       <= 1'b0;
          f_q        <= F_W'(k_q) * F_W'(sr_eff);
          state_q    <= S_MAC;
        end
        S_MAC: begin
          v1_q <= rd_en;
          v2_q <= v1_q;
          if (rd_en) begin
            n_q   <= n_q + 1'b1;
            idx_q <= idx_q + ADDR_W'(k_q);
            if (n_q == N_LAST) iss_done_q <= 1'b1;
          end
          if (v1_q) begin
            pre_q <= x_q * c_q;
            pim_q <= x_q * s_q;
          end
          if (v2_q) begin
            re_q <= re_q + ACC_W'(pre_q);
            im_q <= im_q - ACC_W'(pim_q);
          end
          if (iss_done_q && !v1_q && !v2_q) state_q <= S_RND;
        end
        S_RND: begin
          r_q     <= re_rnd[30 +: RND_W];
          i_q     <= im_rnd[30 +: RND_W];
          state_q <= S_SQ;
        end
        S_SQ: begin
          rr_q    <= r_q * r_q;
          ii_q    <= i_q * i_q;
          state_q <= S_SUM;
        end
        S_SUM: begin
          rad_q   <= SQ_W'(rr_q) + SQ_W'(ii_q);
          root_q  <= '0;
          rem_q   <= '0;
          step_q  <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          rad_q <= rad_q << 2;
          if (sq_rem >= sq_trial) begin
            rem_q  <= sq_rem - sq_trial;
            root_q <= {root_q[ROOT_W-2:0], 1'b1};
          end else begin
            rem_q  <= sq_rem;
            root_q <= {root_q[ROOT_W-2:0], 1'b0};
          end
          if (step_q == SQRT_LAST) begin
            div_num_q <= DIV_W'({root_q[ROOT_W-2:0], sq_rem >= sq_trial});
            div_den_q <= TOT_W'(sr_eff);
            div_rem_q <= '0;
            div_ret_q <= 1'b0;
            step_q    <= '0;
            state_q   <= S_DIV;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_DIV: begin
          div_num_q <= div_num_d;
          div_rem_q <= dv_rem;
          if (step_q == DIV_LAST) begin
            step_q <= '0;
            if (div_ret_q) begin
              share_q[j_q] <= div_num_d[SHARE_W-1:0];
              if (j_q == J_LAST) begin
                j_q     <= '0;
                p_q     <= '0;
                score_q <= '0;
                state_q <= S_DIF;
              end else begin
                j_q     <= j_q + 1'b1;
                state_q <= S_SHR;
              end
            end else begin
              mag_q   <= div_num_d[ROOT_W-1:0];
              state_q <= S_BAND;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_BAND: begin
          if (band_hit) band_q[band_idx] <= band_rd + BAND_E_W'(mag_q);
          if (k_q == K_LAST) begin
            j_q     <= '0;
            state_q <= S_TOT;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_BIN;
          end
        end
        S_TOT: begin
          total_q <= total_q + TOT_W'(band_rd);
          if (j_q == J_LAST) begin
            j_q     <= '0;
            state_q <= S_SHR;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_SHR: begin
          div_num_q <= DIV_W'(band_rd) << 16;
          div_den_q <= total_q;
          div_rem_q <= '0;
          div_ret_q <= 1'b1;
          step_q    <= '0;
          state_q   <= S_DIV;
        end
        S_DIF: begin
          d_q     <= $signed({1'b0, TGT_ROM[tgt_idx]}) - $signed({1'b0, share_q[j_q]});
          state_q <= S_MUL;
        end
        S_MUL: begin
          sqd_q   <= sq_full[2*SHARE_W-1:0];
          state_q <= S_ACC;
        end
        S_ACC: begin
          state_q <= S_DIF;
          if (j_q == J_LAST) begin
            j_q     <= '0;
            score_q <= '0;
            if (p_q == '0 || score_d < best_score_q) begin
              best_score_q <= score_d;
              best_q       <= p_q;
            end
            if (p_q == J_LAST) begin
              res_q.status       <= STATUS_OK;
              res_q.preset_index <= (p_q == '0 || score_d < best_score_q) ? p_q : best_q;
              state_q            <= S_IDLE;
            end else begin
              p_q <= p_q + 1'b1;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            score_q <= score_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `OBPC_ASSERT(a_done_idle, done_o |-> !busy)
  `OBPC_ASSERT(a_len_err_zero, (done_o && result_o.status == STATUS_LEN) |-> (result_o.preset_index == '0))
  `OBPC_ASSERT_NEVER(a_cnt_sat, cnt_q > CNT_N + 1'b1)
  `OBPC_ASSERT_NEVER(a_best_range, best_q > J_LAST)

endmodule
